@@ src/sams_pkg.sv @@
// ----------------------------------------------------------------------------
// sams_pkg
// Shared types and constants for the sprite animation and move sequencer.
// ----------------------------------------------------------------------------
package sams_pkg;

  localparam int unsigned FrameW  = 8;
  localparam int unsigned TickW   = 16;
  localparam int unsigned OffsetW = 9;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;

  // remainder unit widths: dividend is at most tick_count + 1
  localparam int unsigned DivNumW = TickW + 1;
  localparam int unsigned DivDenW = 2 * TickW;
  localparam int unsigned DivCntW = 5;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_FRAME_COUNT = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_FRAME_TICKS = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_LOOP_MODE   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_TURN_PAUSE  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MOVE_TICKS  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_TICK_WRAP   = 3'd5;

  localparam logic LOOP_PING_PONG = 1'b1;
  localparam logic MODE_START     = 1'b1;

  // configuration as seen by the sequencer, zero divisors already forced to one
  typedef struct packed {
    logic [FrameW-1:0] frame_count;
    logic [TickW-1:0]  frame_ticks;
    logic              loop_mode;
    logic [TickW-1:0]  turn_pause;
    logic [TickW-1:0]  move_ticks;
    logic [TickW-1:0]  tick_wrap;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] dividend;  // left aligned, msb first
    logic [DivDenW-1:0] divisor;
    logic [DivCntW-1:0] nbits;
  } div_cmd_t;

  typedef struct packed {
    logic               done;
    logic [DivNumW-1:0] rem;
  } div_rsp_t;

endpackage

@@ src/sams_cfg.sv @@
// ----------------------------------------------------------------------------
// sams_cfg
// Configuration registers with write port and zero-divisor clamping.
// ----------------------------------------------------------------------------
module sams_cfg
  import sams_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_addr_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  output cfg_t               cfg_o
);

  logic [FrameW-1:0] frame_count_q;
  logic [TickW-1:0]  tpf_q;
  logic              loop_mode_q;
  logic [TickW-1:0]  wait_loop_q;
  logic [TickW-1:0]  tpm_q;
  logic [TickW-1:0]  tick_wrap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= FrameW'(1);
      tpf_q         <= TickW'(1);
      loop_mode_q   <= 1'b0;
      wait_loop_q   <= '0;
      tpm_q         <= TickW'(1);
      tick_wrap_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_FRAME_COUNT: frame_count_q <= cfg_wdata_i[FrameW-1:0];
        REG_FRAME_TICKS: tpf_q         <= cfg_wdata_i;
        REG_LOOP_MODE:   loop_mode_q   <= cfg_wdata_i[0];
        REG_TURN_PAUSE:  wait_loop_q   <= cfg_wdata_i;
        REG_MOVE_TICKS:  tpm_q         <= cfg_wdata_i;
        REG_TICK_WRAP:   tick_wrap_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // a zero count or divisor behaves as one
  always_comb begin
    cfg_o.frame_count = (frame_count_q == '0) ? FrameW'(1) : frame_count_q;
    cfg_o.frame_ticks = (tpf_q == '0) ? TickW'(1) : tpf_q;
    cfg_o.loop_mode   = loop_mode_q;
    cfg_o.turn_pause  = wait_loop_q;
    cfg_o.move_ticks  = (tpm_q == '0) ? TickW'(1) : tpm_q;
    cfg_o.tick_wrap   = tick_wrap_q;
  end

endmodule

@@ src/sams_rem.sv @@
// ----------------------------------------------------------------------------
// sams_rem
// Shared restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module sams_rem
  import sams_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_cmd_t cmd_i,
  output div_rsp_t rsp_o
);

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DivNumW-1:0] num_q;
  logic [DivNumW-1:0] rem_q;
  logic [DivDenW-1:0] den_q;

  logic [DivNumW-1:0] shifted;
  logic               ge;
  logic [DivNumW-1:0] rem_d;

  // partial remainder never exceeds the dividend prefix, so it fits DivNumW
  always_comb begin
    shifted = {rem_q[DivNumW-2:0], num_q[DivNumW-1]};
    ge      = {{(DivDenW-DivNumW){1'b0}}, shifted} >= den_q;
    rem_d   = ge ? (shifted - den_q[DivNumW-1:0]) : shifted;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= cmd_i.nbits;
      end else if (busy_q) begin
        if (cnt_q == DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q - DivCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      num_q <= cmd_i.dividend;
      rem_q <= '0;
      den_q <= cmd_i.divisor;
    end else if (busy_q) begin
      num_q <= {num_q[DivNumW-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |-> !busy_q)
    else $error("remainder unit restarted while busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("remainder done while still busy");

endmodule

@@ src/sprite_anim_move_sequencer.sv @@
// ----------------------------------------------------------------------------
// sprite_anim_move_sequencer
// Animation frame and sub-tile offset sequencer for one sprite axis.
// ----------------------------------------------------------------------------
// One item is taken at a time. A start item or a tick with a zero offset
// goes straight to the done state. A tick with a nonzero offset runs up to
// four remainder operations on one shared restoring unit that retires one
// dividend bit per cycle: the tick modulus (17 bits, only when the
// incremented count reaches the modulus), the frame boundary test (16
// bits), the frame wrap when counting up (9 bits, only on a frame boundary)
// and the offset step test (16 bits). While a ping-pong wait is pending
// only the offset step test runs. The result sits in an output
// register until transferred; the next item is taken once the result
// is registered.
module sprite_anim_move_sequencer
  import sams_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_addr_i,
  input  logic [CfgW-1:0]           cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      mode_i,
  input  logic signed [OffsetW-1:0] start_offset_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [FrameW-1:0]         frame_out_o,
  output logic signed [OffsetW-1:0] offset_out_o,
  output logic signed [OffsetW-1:0] prev_offset_out_o,
  output logic                      moving_o,
  output logic                      frame_advanced_o
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_PREP   = 10'b00_0000_0010,
    S_TICK   = 10'b00_0000_0100,
    S_TICK_W = 10'b00_0000_1000,
    S_FRM    = 10'b00_0001_0000,
    S_FRM_W  = 10'b00_0010_0000,
    S_UP_W   = 10'b00_0100_0000,
    S_MOVE   = 10'b00_1000_0000,
    S_MOVE_W = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } state_e;

  cfg_t     cfg;
  div_cmd_t div_cmd;
  div_rsp_t div_rsp;

  state_e                      state_q, state_d;
  logic [TickW-1:0]            tick_q, tick_d;
  logic [TickW-1:0]            wait_q, wait_d;
  logic [FrameW-1:0]           frame_q, frame_d;
  logic                        up_q, up_d;
  logic signed [OffsetW-1:0]   off_q, off_d;
  logic signed [OffsetW-1:0]   prev_q, prev_d;
  logic                        moving_q, moving_d;
  logic                        adv_q, adv_d;
  logic [DivDenW-1:0]          modulus_q, modulus_d;

  logic                        out_valid_q;
  logic [FrameW-1:0]           frame_out_q;
  logic signed [OffsetW-1:0]   offset_out_q;
  logic signed [OffsetW-1:0]   prev_out_q;
  logic                        moving_out_q;
  logic                        adv_out_q;
  logic                        out_load;

  logic [DivNumW-1:0]          tick_inc;
  logic [FrameW-1:0]           turn_min;
  logic [FrameW:0]             frame_inc;

  sams_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  sams_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd),
    .rsp_o  (div_rsp)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign tick_inc   = {1'b0, tick_q} + DivNumW'(1);
  assign turn_min   = (cfg.frame_count > FrameW'(1)) ? FrameW'(2) : FrameW'(1);
  assign frame_inc  = {1'b0, frame_q} + (FrameW+1)'(1);
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d   = state_q;
    tick_d    = tick_q;
    wait_d    = wait_q;
    frame_d   = frame_q;
    up_d      = up_q;
    off_d     = off_q;
    prev_d    = prev_q;
    moving_d  = moving_q;
    adv_d     = adv_q;
    modulus_d = modulus_q;
    div_cmd   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          adv_d = 1'b0;
          if (mode_i == MODE_START) begin
            off_d    = start_offset_i;
            prev_d   = '0;
            moving_d = 1'b0;
            state_d  = S_DONE;
          end else begin
            prev_d   = off_q;
            moving_d = (off_q != '0);
            if (off_q != '0) begin
              state_d = S_PREP;
            end else begin
              tick_d  = tick_q + TickW'(1);
              state_d = S_DONE;
            end
          end
        end
      end
      S_PREP: begin
        modulus_d = (cfg.tick_wrap != '0) ? {{TickW{1'b0}}, cfg.tick_wrap}
                                          : DivDenW'(cfg.frame_ticks) * DivDenW'(cfg.move_ticks);
        if (wait_q != '0) begin
          // ping-pong pause: tick and frame hold
          wait_d  = wait_q - TickW'(1);
          state_d = S_MOVE;
        end else begin
          state_d = S_TICK;
        end
      end
      S_TICK: begin
        if (modulus_q > {{(DivDenW-DivNumW){1'b0}}, tick_inc}) begin
          tick_d  = tick_inc[TickW-1:0];
          state_d = S_FRM;
        end else begin
          div_cmd.start    = 1'b1;
          div_cmd.dividend = tick_inc;
          div_cmd.divisor  = modulus_q;
          div_cmd.nbits    = DivCntW'(DivNumW);
          state_d          = S_TICK_W;
        end
      end
      S_TICK_W: begin
        if (div_rsp.done) begin
          tick_d  = div_rsp.rem[TickW-1:0];
          state_d = S_FRM;
        end
      end
      S_FRM: begin
        div_cmd.start    = 1'b1;
        div_cmd.dividend = {tick_q, 1'b0};
        div_cmd.divisor  = {{(DivDenW-TickW){1'b0}}, cfg.frame_ticks};
        div_cmd.nbits    = DivCntW'(TickW);
        state_d          = S_FRM_W;
      end
      S_FRM_W: begin
        if (div_rsp.done) begin
          if (div_rsp.rem != '0) begin
            state_d = S_MOVE;
          end else begin
            adv_d = 1'b1;
            if (up_q) begin
              div_cmd.start    = 1'b1;
              div_cmd.dividend = {frame_inc, {(DivNumW-FrameW-1){1'b0}}};
              div_cmd.divisor  = {{(DivDenW-FrameW){1'b0}}, cfg.frame_count};
              div_cmd.nbits    = DivCntW'(FrameW + 1);
              state_d          = S_UP_W;
            end else begin
              if (frame_q == '0) begin
                if (cfg.loop_mode == LOOP_PING_PONG) begin
                  up_d    = 1'b1;
                  wait_d  = cfg.turn_pause;
                  frame_d = turn_min - FrameW'(1);
                end else begin
                  frame_d = cfg.frame_count - FrameW'(1);
                end
              end else begin
                frame_d = frame_q - FrameW'(1);
              end
              state_d = S_MOVE;
            end
          end
        end
      end
      S_UP_W: begin
        if (div_rsp.done) begin
          if (div_rsp.rem[FrameW-1:0] == '0 && cfg.loop_mode == LOOP_PING_PONG) begin
            up_d    = 1'b0;
            wait_d  = cfg.turn_pause;
            frame_d = cfg.frame_count - turn_min;
          end else begin
            frame_d = div_rsp.rem[FrameW-1:0];
          end
          state_d = S_MOVE;
        end
      end
      S_MOVE: begin
        div_cmd.start    = 1'b1;
        div_cmd.dividend = {tick_q, 1'b0};
        div_cmd.divisor  = {{(DivDenW-TickW){1'b0}}, cfg.move_ticks};
        div_cmd.nbits    = DivCntW'(TickW);
        state_d          = S_MOVE_W;
      end
      S_MOVE_W: begin
        if (div_rsp.done) begin
          if (div_rsp.rem == '0) begin
            // one step toward zero
            off_d = off_q[OffsetW-1] ? (off_q + OffsetW'(1)) : (off_q - OffsetW'(1));
          end
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      tick_q   <= '0;
      wait_q   <= '0;
      frame_q  <= '0;
      up_q     <= 1'b1;
      off_q    <= '0;
      prev_q   <= '0;
      moving_q <= 1'b0;
      adv_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      tick_q   <= tick_d;
      wait_q   <= wait_d;
      frame_q  <= frame_d;
      up_q     <= up_d;
      off_q    <= off_d;
      prev_q   <= prev_d;
      moving_q <= moving_d;
      adv_q    <= adv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    modulus_q <= modulus_d;
  end

  // output register, holds the result until transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      frame_out_q  <= frame_q;
      offset_out_q <= off_q;
      prev_out_q   <= prev_q;
      moving_out_q <= moving_q;
      adv_out_q    <= adv_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign frame_out_o       = frame_out_q;
  assign offset_out_o      = offset_out_q;
  assign prev_offset_out_o = prev_out_q;
  assign moving_o          = moving_out_q;
  assign frame_advanced_o  = adv_out_q;

  a_start_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && mode_i == MODE_START)
    |=> (off_q == $past(start_offset_i)) && (prev_q == '0))
    else $error("start transfer did not load the offset");

  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && mode_i != MODE_START && off_q == '0)
    |=> (tick_q == $past(tick_q) + TickW'(1)) && (state_q == S_DONE))
    else $error("idle tick did not advance the tick counter");

  a_rem_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_TICK_W || state_q == S_FRM_W ||
                      state_q == S_UP_W || state_q == S_MOVE_W))
    else $error("remainder result arrived outside a wait state");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_DONE)
    else $error("result registered outside the done state");

endmodule

@@ sim/sprite_anim_move_sequencer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_anim_move_sequencer_tb
// Self-checking bench for the one-axis sprite animation and move sequencer.
// Move starts and ticks are pushed through the input channel while a local
// model of the frame, tick, wait and offset state predicts every result. The
// registers are reprogrammed between runs while the block is idle, and
// both channels idle and stall at random.
// ----------------------------------------------------------------------------
module sprite_anim_move_sequencer_tb;
  import sams_pkg::*;

  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS    = 50;
  localparam logic        MODE_TICK      = 1'b0;

  typedef struct packed {
    logic               mode;
    logic [OffsetW-1:0] offset;
  } anim_cmd_t;

  typedef struct packed {
    logic [FrameW-1:0]  frame;
    logic [OffsetW-1:0] offset;
    logic [OffsetW-1:0] prev_offset;
    logic               moving;
    logic               advanced;
  } motion_t;

  logic                      clk_i             = 1'b0;
  logic                      rst_ni            = 1'b0;
  logic                      cfg_we_i          = 1'b0;
  logic [CfgIdxW-1:0]        cfg_addr_i        = '0;
  logic [CfgW-1:0]           cfg_wdata_i       = '0;
  logic                      in_valid_i        = 1'b0;
  logic                      in_ready_o;
  logic                      mode_i            = 1'b0;
  logic signed [OffsetW-1:0] start_offset_i    = '0;
  logic                      out_valid_o;
  logic                      out_ready_i       = 1'b0;
  logic [FrameW-1:0]         frame_out_o;
  logic signed [OffsetW-1:0] offset_out_o;
  logic signed [OffsetW-1:0] prev_offset_out_o;
  logic                      moving_o;
  logic                      frame_advanced_o;

  sprite_anim_move_sequencer u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode_i),
    .start_offset_i   (start_offset_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .frame_out_o      (frame_out_o),
    .offset_out_o     (offset_out_o),
    .prev_offset_out_o(prev_offset_out_o),
    .moving_o         (moving_o),
    .frame_advanced_o (frame_advanced_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // predicted sequencer state and register copy
  cfg_t               regs;
  logic [TickW-1:0]   tick_q          = '0;
  logic [TickW-1:0]   wait_q          = '0;
  logic [FrameW-1:0]  frame_q         = '0;
  logic               counting_up_q   = 1'b1;
  logic [OffsetW-1:0] offset_q        = '0;
  logic [OffsetW-1:0] prev_offset_q   = '0;

  anim_cmd_t   cmd_q[$];
  motion_t     motion_q[$];
  bit          idle_on = 1'b1;
  int unsigned send_hold = 0;
  int unsigned recv_hold = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned n_starts = 0, n_idle = 0, n_moving = 0, n_steps = 0, n_waits = 0;
  int unsigned n_results = 0, n_settings = 0;

  function automatic int unsigned draw_idle();
    return idle_on ? $urandom_range(0, 9) : 0;
  endfunction

  // one item through the local model, returns the result it should produce
  function automatic motion_t advance_sequencer(input logic mode,
                                                input logic [OffsetW-1:0] start);
    motion_t         r;
    longint unsigned fc, tpf, tpm, modulus;
    r   = '0;
    fc  = (regs.frame_count == '0) ? 1 : longint'(regs.frame_count);
    tpf = (regs.frame_ticks == '0) ? 1 : longint'(regs.frame_ticks);
    tpm = (regs.move_ticks == '0) ? 1 : longint'(regs.move_ticks);
    if (mode == MODE_START) begin
      offset_q      = start;
      prev_offset_q = '0;
      n_starts++;
    end else begin
      r.moving      = (offset_q != '0);
      prev_offset_q = offset_q;
      if (!r.moving) begin
        // idle ticks ignore the modulus
        tick_q = tick_q + 1'b1;
        n_idle++;
      end else begin
        n_moving++;
        if (wait_q != '0) begin
          wait_q = wait_q - 1'b1;
          n_waits++;
        end else begin
          modulus = (regs.tick_wrap != '0) ? longint'(regs.tick_wrap) : tpf * tpm;
          tick_q  = TickW'((longint'(tick_q) + 1) % modulus);
          if (longint'(tick_q) % tpf == 0) begin
            r.advanced = 1'b1;
            n_steps++;
            if (counting_up_q) begin
              frame_q = FrameW'((longint'(frame_q) + 1) % fc);
              if (frame_q == '0 && regs.loop_mode == LOOP_PING_PONG) begin
                counting_up_q = 1'b0;
                frame_q       = FrameW'(fc - ((fc > 1) ? 2 : 1));
                wait_q        = regs.turn_pause;
              end
            end else begin
              if (frame_q == '0) begin
                if (regs.loop_mode == LOOP_PING_PONG) begin
                  counting_up_q = 1'b1;
                  frame_q       = (fc > 1) ? 8'd2 : 8'd1;
                  wait_q        = regs.turn_pause;
                end else begin
                  frame_q = FrameW'(fc);
                end
              end
              frame_q = frame_q - 1'b1;
            end
          end
        end
        // offset step uses the tick count as it stands, even while waiting
        if (longint'(tick_q) % tpm == 0) begin
          offset_q = offset_q[OffsetW-1] ? offset_q + 1'b1 : offset_q - 1'b1;
        end
      end
    end
    r.frame       = frame_q;
    r.offset      = offset_q;
    r.prev_offset = prev_offset_q;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // input side: one transfer per item, random gap before each
  always @(posedge clk_i or negedge rst_ni) begin : cmd_driver
    int unsigned hold;
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      mode_i         <= 1'b0;
      start_offset_i <= '0;
      send_hold      <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) motion_q.push_back(advance_sequencer(mode_i, start_offset_i));
      hold = in_valid_i ? draw_idle() : send_hold;
      if (hold != 0) begin
        in_valid_i <= 1'b0;
        send_hold  <= hold - 1;
      end else if (cmd_q.size() != 0) begin
        in_valid_i     <= 1'b1;
        mode_i         <= cmd_q[0].mode;
        start_offset_i <= cmd_q[0].offset;
        cmd_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output side: check each transfer, then stall a random number of cycles
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    int unsigned hold;
    motion_t     want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_hold   <= 0;
    end else begin
      hold = recv_hold;
      if (out_valid_o && out_ready_i) begin
        n_results++;
        hold = draw_idle();
        if (motion_q.size() == 0) begin
          report_mismatch("result transfer with no result pending");
        end else begin
          want = motion_q.pop_front();
          if (frame_out_o !== want.frame)
            report_mismatch($sformatf("frame_out got %0d want %0d", frame_out_o, want.frame));
          if (offset_out_o !== want.offset)
            report_mismatch($sformatf("offset_out got %0d want %0d",
                                      offset_out_o, $signed(want.offset)));
          if (prev_offset_out_o !== want.prev_offset)
            report_mismatch($sformatf("prev_offset_out got %0d want %0d",
                                      prev_offset_out_o, $signed(want.prev_offset)));
          if (moving_o !== want.moving)
            report_mismatch($sformatf("moving got %0b want %0b", moving_o, want.moving));
          if (frame_advanced_o !== want.advanced)
            report_mismatch($sformatf("frame_advanced got %0b want %0b",
                                      frame_advanced_o, want.advanced));
        end
      end
      if (hold != 0) begin
        out_ready_i <= 1'b0;
        recv_hold   <= hold - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] timeout: no transfer for %0d cycles", $time, quiet_cycles);
      $display("sprite_anim_move_sequencer_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_cmd(input logic mode, input logic [OffsetW-1:0] offset);
    anim_cmd_t c;
    c.mode   = mode;
    c.offset = offset;
    cmd_q.push_back(c);
  endtask

  task automatic push_ticks(input int unsigned count);
    repeat (count) push_cmd(MODE_TICK, OffsetW'($urandom));
  endtask

  function automatic logic [OffsetW-1:0] draw_offset();
    logic [OffsetW-1:0] mag;
    if ($urandom_range(0, 3) == 0) return OffsetW'($urandom);
    mag = OffsetW'($urandom_range(1, 12));
    return ($urandom_range(0, 1) != 0) ? -mag : mag;
  endfunction

  // mostly a move start followed by a run of ticks, some loose items between
  task automatic queue_random_moves(input int unsigned n_items);
    int unsigned queued;
    int unsigned run_len;
    queued = 0;
    while (queued < n_items) begin
      if ($urandom_range(0, 7) == 0) begin
        push_cmd(1'($urandom_range(0, 1)), OffsetW'($urandom));
        queued++;
      end else begin
        run_len = $urandom_range(1, 30);
        push_cmd(MODE_START, draw_offset());
        push_ticks(run_len);
        queued += run_len + 1;
      end
    end
  endtask

  task automatic wait_drained();
    while (cmd_q.size() != 0 || in_valid_i || motion_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    case (idx)
      REG_FRAME_COUNT: regs.frame_count = value[FrameW-1:0];
      REG_FRAME_TICKS: regs.frame_ticks = value;
      REG_LOOP_MODE:   regs.loop_mode   = value[0];
      REG_TURN_PAUSE:  regs.turn_pause  = value;
      REG_MOVE_TICKS:  regs.move_ticks  = value;
      REG_TICK_WRAP:   regs.tick_wrap   = value;
      default: ;
    endcase
  endtask

  task automatic program_regs(input int unsigned frames, input int unsigned tpf,
                              input int unsigned loop, input int unsigned wait_ticks,
                              input int unsigned tpm, input int unsigned wrap);
    write_reg(REG_FRAME_COUNT, CfgW'(frames));
    write_reg(REG_FRAME_TICKS, CfgW'(tpf));
    write_reg(REG_LOOP_MODE, CfgW'(loop));
    write_reg(REG_TURN_PAUSE, CfgW'(wait_ticks));
    write_reg(REG_MOVE_TICKS, CfgW'(tpm));
    write_reg(REG_TICK_WRAP, CfgW'(wrap));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  task automatic run_setting(input int unsigned frames, input int unsigned tpf,
                             input int unsigned loop, input int unsigned wait_ticks,
                             input int unsigned tpm, input int unsigned wrap);
    program_regs(frames, tpf, loop, wait_ticks, tpm, wrap);
    idle_on = ($urandom_range(0, 3) != 0);
    queue_random_moves(120);
    wait_drained();
  endtask

  initial begin : stimulus
    regs = '{frame_count: 8'd1, frame_ticks: 16'd1, loop_mode: 1'b0,
             turn_pause: 16'd0, move_ticks: 16'd1, tick_wrap: 16'd0};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // field extremes under the reset settings, including the -256 offset
    push_cmd(MODE_START, 9'sd255);
    push_ticks(3);
    push_cmd(MODE_START, 9'h100);
    push_ticks(2);
    push_cmd(MODE_START, 9'sd0);
    push_ticks(2);
    push_cmd(MODE_START, -9'sd1);
    push_ticks(2);
    push_cmd(MODE_START, 9'sd1);
    push_cmd(MODE_START, -9'sd255);
    push_ticks(2);
    push_cmd(MODE_START, 9'h0AA);
    push_cmd(MODE_START, 9'h155);
    push_ticks(2);
    wait_drained();

    run_setting(1, 1, 0, 0, 1, 0);
    run_setting(4, 1, 1, 0, 1, 0);
    run_setting(5, 2, 1, 3, 3, 0);
    run_setting(0, 0, 1, 2, 0, 0);
    run_setting(255, 1, 0, 0, 1, 0);
    run_setting(3, 1, 0, 0, 2, 5);
    run_setting(6, 3, 1, 1, 2, 0);
    run_setting(2, 1, 1, 0, 1, 4);
    run_setting(7, 65535, 0, 0, 65535, 65535);
    run_setting(1, 1, 1, 5, 1, 1);
    repeat (4) begin
      run_setting($urandom_range(0, 9), $urandom_range(0, 4), $urandom_range(0, 1),
                  $urandom_range(0, 4), $urandom_range(0, 4),
                  ($urandom_range(0, 1) != 0) ? $urandom_range(1, 12) : 0);
    end
    // longest ping-pong pause last, it holds the frame for the rest of the run
    run_setting(3, 1, 1, 65535, 1, 0);

    repeat (100) @(posedge clk_i);
    $display("covered %0d starts, %0d idle ticks and %0d moving ticks over %0d settings",
             n_starts, n_idle, n_moving, n_settings);
    $display("%0d frame steps, %0d ping-pong wait ticks, %0d results checked, %0d mismatches",
             n_steps, n_waits, n_results, mismatches);
    if (mismatches == 0 && motion_q.size() == 0) begin
      $display("sprite_anim_move_sequencer_tb: PASS");
    end else begin
      $display("sprite_anim_move_sequencer_tb: FAIL");
    end
    $finish;
  end

endmodule
